>>> hw/rtl/pol_pkg.sv
// Shared constants, codes and control types for the positional ordered list.
package pol_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ID_W   = 10;
  localparam int PAIR_W = 2 * ID_W;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DELETE    = 3'd3,
    CMD_COUNT     = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INS,
    KIND_DEL,
    KIND_CNT,
    KIND_RD
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_LOOP,
    S_PLACE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic place;
    logic commit;
  } dp_ctrl_t;

  typedef struct packed {
    kind_t kind;
    logic  loop_done;
  } dp_stat_t;

endpackage

>>> hw/rtl/pol_datapath.sv
// Datapath: entry memory, walk pointer, match counter and result register.
module pol_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [pol_pkg::IN_W-1:0]  in_tdata,
  input  pol_pkg::dp_ctrl_t     ctrl,
  output pol_pkg::dp_stat_t     stat,
  output logic [pol_pkg::OUT_W-1:0] out_tdata
);
  import pol_pkg::*;

  logic [PAIR_W-1:0] mem [DEPTH];
  logic [PAIR_W-1:0] rd_data_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [PAIR_W-1:0] pair_r;
  logic [POS_W-1:0]  pos_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, stop_r;
  logic              up_r;
  kind_t             kind_r;
  status_t           status_r;
  logic              pend_r;
  logic [IDX_W-1:0]  dst_r;
  logic [CNT_W-1:0]  match_r;
  logic [PAIR_W-1:0] rd_val_r;
  logic [OUT_W-1:0]  out_r;

  // request decode
  logic [CMP_W-1:0]  pos_x, cnt_x;
  logic              pos_bad, full;
  logic [CNT_W-1:0]  pos_m1, slot;
  kind_t             kind_s;
  status_t           status_s;
  logic [CNT_W-1:0]  ptr_s, stop_s;
  logic              up_s;

  // walk
  logic              issue;
  logic [CNT_W-1:0]  src;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [PAIR_W-1:0] wr_data;

  always_comb begin
    pos_x   = CMP_W'(pos_r);
    cnt_x   = CMP_W'(count_r);
    pos_bad = (pos_r == '0) || (pos_x > cnt_x);
    full    = (count_r == CNT_W'(DEPTH));
    pos_m1  = CNT_W'(pos_x - CMP_W'(1));
    slot    = (pos_x > cnt_x) ? count_r : pos_m1;
    kind_s   = KIND_NONE;
    status_s = ST_OK;
    ptr_s    = '0;
    stop_s   = '0;
    up_s     = 1'b1;
    unique case (cmd_r) inside
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (full) begin
          status_s = ST_FULL;
        end else if ((cmd_r == CMD_INS_POS) && (pos_r == '0)) begin
          status_s = ST_RANGE;
        end else begin
          kind_s = KIND_INS;
          ptr_s  = count_r;
          up_s   = 1'b0;
          if (cmd_r == CMD_INS_FRONT) begin
            stop_s = '0;
          end else if (cmd_r == CMD_INS_BACK) begin
            stop_s = count_r;
          end else begin
            stop_s = slot;
          end
        end
      end
      CMD_DELETE: begin
        if (pos_bad) begin
          status_s = ST_RANGE;
        end else begin
          kind_s = KIND_DEL;
          ptr_s  = pos_m1;
          stop_s = count_r - CNT_W'(1);
        end
      end
      CMD_COUNT: begin
        kind_s = KIND_CNT;
        stop_s = count_r;
      end
      CMD_READ: begin
        if (pos_bad) begin
          status_s = ST_RANGE;
        end else begin
          kind_s = KIND_RD;
          ptr_s  = pos_m1;
          stop_s = CNT_W'(pos_x);
        end
      end
      default: ;
    endcase
  end

  assign issue = ctrl.step && (ptr_r != stop_r);

  always_comb begin
    case (kind_r)
      KIND_INS: src = ptr_r - CNT_W'(1);
      KIND_DEL: src = ptr_r + CNT_W'(1);
      default:  src = ptr_r;
    endcase
  end

  // shift writes trail their reads, landing in the cycle after each read
  assign wr_en   = ctrl.place ||
                   (ctrl.step && pend_r && ((kind_r == KIND_INS) || (kind_r == KIND_DEL)));
  assign wr_addr = ctrl.place ? stop_r[IDX_W-1:0] : dst_r;
  assign wr_data = ctrl.place ? pair_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[src[IDX_W-1:0]];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (kind_r == KIND_INS) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (kind_r == KIND_DEL) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      kind_r  <= KIND_NONE;
    end else begin
      if (ctrl.setup) begin
        kind_r <= kind_s;
        pend_r <= 1'b0;
      end else if (ctrl.step) begin
        pend_r <= issue;
      end
      if (ctrl.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_tdata[2:0];
      pair_r <= {in_tdata[12:3], in_tdata[22:13]};
      pos_r  <= in_tdata[30:23];
    end
    if (ctrl.setup) begin
      status_r <= status_s;
      ptr_r    <= ptr_s;
      stop_r   <= stop_s;
      up_r     <= up_s;
      match_r  <= '0;
      rd_val_r <= '0;
    end else if (ctrl.step) begin
      if (issue) begin
        dst_r <= ptr_r[IDX_W-1:0];
        ptr_r <= up_r ? (ptr_r + CNT_W'(1)) : (ptr_r - CNT_W'(1));
      end
      if (pend_r) begin
        if ((kind_r == KIND_CNT) && (rd_data_r == pair_r)) begin
          match_r <= match_r + CNT_W'(1);
        end
        if (kind_r == KIND_RD) begin
          rd_val_r <= rd_data_r;
        end
      end
    end
    if (ctrl.commit) begin
      out_r <= {rd_val_r[ID_W-1:0], rd_val_r[PAIR_W-1:ID_W],
                LEN_W'(match_r), LEN_W'(count_nxt), status_r};
    end
  end

  assign stat.kind      = kind_r;
  assign stat.loop_done = (ptr_r == stop_r) && !pend_r;
  assign out_tdata      = out_r;

endmodule

>>> hw/rtl/pol_ctrl.sv
// Controller: command sequencing and result register handshake.
module pol_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pol_pkg::dp_stat_t stat,
  output pol_pkg::dp_ctrl_t ctrl
);
  import pol_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = S_LOOP;
      S_LOOP: begin
        if (stat.loop_done) begin
          state_nxt = (stat.kind == KIND_INS) ? S_PLACE : S_FINISH;
        end
      end
      S_PLACE:  state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ctrl.load = in_tvalid;
      end
      S_SETUP:  ctrl.setup  = 1'b1;
      S_LOOP:   ctrl.step   = 1'b1;
      S_PLACE:  ctrl.place  = 1'b1;
      S_FINISH: ctrl.commit = out_free;
      default: ;
    endcase
  end

  // hold the result until taken; a fresh load wins over the drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hw/rtl/positional_ordered_list.sv
// Ordered list of (college id, course id) pairs with positional insert, delete, count, read.
//
// Input stream: one request per command (insert front, insert back, insert at
// one-based position, delete, count matching pairs, read). Output stream: one
// result per request with status, list length after the command, match count
// and the pair read. Requests are handled one at a time, in order.
// Each request is loaded, set up, walked over the entries it touches with a
// final drain of the memory read, given a place step if it is an accepted
// insert, and finished by loading the result. Insert and delete shift the
// entries behind the position one per cycle through the single read and
// write port of the entry memory; count compares one entry per cycle; read
// touches one entry. The next request is taken in the cycle after the result
// is loaded.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver only stops the block at the point where the
// following result needs that register.
// Reset (synchronous, active low) empties the list; entry contents are not
// cleared, only entries inside the current length are ever read.
module positional_ordered_list (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // cmd[2:0], college_id[12:3], course_id[22:13], position[30:23], zero pad[31]
  input  logic [pol_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status[1:0], list_length[6:2], match_count[11:7], read_college[21:12],
  // read_course[31:22]
  output logic [pol_pkg::OUT_W-1:0]  out_tdata
);
  import pol_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  pol_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  pol_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

>>> test/tb_positional_ordered_list.sv
// Self-checking stream testbench for the positional ordered list of college/course pairs.
module tb_positional_ordered_list;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_CAP   = 100;
  // codes past the defined commands; the block must treat them as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  college;
    logic [ID_W-1:0]  course;
    logic [POS_W-1:0] pos;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  match_cnt;
    logic [ID_W-1:0]   rd_college;
    logic [ID_W-1:0]   rd_course;
  } list_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  list_req_t         pending_requests[$];
  list_reply_t       predicted_replies[$];
  logic [PAIR_W-1:0] roster[$];
  list_req_t         in_flight;
  int                send_gap = 0;
  int                hold_left = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                calm = 1'b0;

  positional_ordered_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the reply it must produce.
  function automatic list_reply_t apply_request(list_req_t r);
    list_reply_t       rep;
    logic [PAIR_W-1:0] pair;
    int                p;
    int                slot;
    rep.status     = ST_OK;
    rep.match_cnt  = '0;
    rep.rd_college = '0;
    rep.rd_course  = '0;
    pair = {r.college, r.course};
    p = r.pos;
    case (r.op)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        // a full list wins over a bad position
        if (roster.size() >= DEPTH) begin
          rep.status = ST_FULL;
        end else if (r.op == CMD_INS_POS && p == 0) begin
          rep.status = ST_RANGE;
        end else begin
          if (r.op == CMD_INS_FRONT) slot = 0;
          else if (r.op == CMD_INS_BACK) slot = roster.size();
          else slot = (p - 1 > roster.size()) ? roster.size() : p - 1;
          roster.insert(slot, pair);
        end
      end
      CMD_DELETE: begin
        if (p == 0 || p > roster.size()) rep.status = ST_RANGE;
        else roster.delete(p - 1);
      end
      CMD_COUNT: begin
        foreach (roster[i]) if (roster[i] == pair) rep.match_cnt++;
      end
      CMD_READ: begin
        if (p == 0 || p > roster.size()) begin
          rep.status = ST_RANGE;
        end else begin
          rep.rd_college = roster[p - 1][PAIR_W-1:ID_W];
          rep.rd_course  = roster[p - 1][ID_W-1:0];
        end
      end
      default: ;
    endcase
    rep.length = LEN_W'(roster.size());
    return rep;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long stretch.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 59) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Draw ids from a small pool most of the time so count finds duplicates.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return ID_W'(341 * $urandom_range(0, 3));
    return ID_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, DEPTH + 1));
  endfunction

  function automatic list_req_t make_request(logic [CMD_W-1:0] op, logic [ID_W-1:0] col,
                                             logic [ID_W-1:0] crs, logic [POS_W-1:0] pos);
    list_req_t r;
    r.op = op;
    r.college = col;
    r.course = crs;
    r.pos = pos;
    return r;
  endfunction

  // Filling phases lean toward inserts, draining phases toward deletes.
  function automatic list_req_t random_request(bit filling);
    logic [CMD_W-1:0] op;
    int               r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 22) op = CMD_INS_FRONT;
      else if (r < 44) op = CMD_INS_BACK;
      else if (r < 66) op = CMD_INS_POS;
      else if (r < 76) op = CMD_DELETE;
      else if (r < 86) op = CMD_COUNT;
      else if (r < 98) op = CMD_READ;
      else op = (r == 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
    end else begin
      if (r < 5) op = CMD_INS_FRONT;
      else if (r < 10) op = CMD_INS_BACK;
      else if (r < 15) op = CMD_INS_POS;
      else if (r < 68) op = CMD_DELETE;
      else if (r < 82) op = CMD_COUNT;
      else if (r < 98) op = CMD_READ;
      else op = (r == 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
    end
    return make_request(op, pick_id(), pick_id(), pick_pos());
  endfunction

  // Request driver: present the next pending request, predict it on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predicted_replies.push_back(apply_request(in_flight));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_flight = pending_requests.pop_front();
          in_tdata  <= {1'b0, in_flight.pos, in_flight.course, in_flight.college, in_flight.op};
          in_tvalid <= 1'b1;
          send_gap  = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status     = out_tdata[1:0];
        got.length     = out_tdata[6:2];
        got.match_cnt  = out_tdata[11:7];
        got.rd_college = out_tdata[21:12];
        got.rd_course  = out_tdata[31:22];
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        end else begin
          want = predicted_replies.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
              $display({"%0t: result mismatch, expected st=%0d len=%0d cnt=%0d rd=%0d/%0d,",
                        " actual st=%0d len=%0d cnt=%0d rd=%0d/%0d"},
                       $time, want.status, want.length, want.match_cnt, want.rd_college,
                       want.rd_course, got.status, got.length, got.match_cnt, got.rd_college,
                       got.rd_course);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    bit filling;
    // empty list: reads, deletes and count all see nothing
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd1));
    pending_requests.push_back(make_request(CMD_DELETE, 10'd0, 10'd0, 8'd1));
    pending_requests.push_back(make_request(CMD_COUNT, 10'd0, 10'd0, 8'd0));
    // positional insert into an empty list becomes the only entry
    pending_requests.push_back(make_request(CMD_INS_POS, 10'd1023, 10'd1023, 8'd5));
    pending_requests.push_back(make_request(CMD_INS_FRONT, 10'd0, 10'd0, 8'd0));
    pending_requests.push_back(make_request(CMD_INS_BACK, 10'd1023, 10'd0, 8'd255));
    pending_requests.push_back(make_request(CMD_INS_POS, 10'd5, 10'd6, 8'd0));
    pending_requests.push_back(make_request(CMD_INS_POS, 10'd0, 10'd1023, 8'd255));
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd0));
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd1));
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd4));
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd5));
    pending_requests.push_back(make_request(CMD_COUNT, 10'd1023, 10'd1023, 8'd0));
    pending_requests.push_back(make_request(CMD_DELETE, 10'd0, 10'd0, 8'd0));
    pending_requests.push_back(make_request(CMD_DELETE, 10'd0, 10'd0, 8'd255));
    pending_requests.push_back(make_request(CMD_DELETE, 10'd0, 10'd0, 8'd2));
    pending_requests.push_back(make_request(CMD_SPARE_LO, 10'd1023, 10'd1023, 8'd255));
    pending_requests.push_back(make_request(CMD_SPARE_HI, 10'd0, 10'd0, 8'd0));
    // fill to the limit with one pair; count must include the last entry
    repeat (DEPTH - 3) pending_requests.push_back(make_request(CMD_INS_BACK, 10'd0, 10'd1023,
                                                               8'd0));
    pending_requests.push_back(make_request(CMD_INS_FRONT, 10'd1, 10'd1, 8'd1));
    pending_requests.push_back(make_request(CMD_INS_POS, 10'd1, 10'd1, 8'd0));
    pending_requests.push_back(make_request(CMD_COUNT, 10'd0, 10'd1023, 8'd0));
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd16));
    pending_requests.push_back(make_request(CMD_DELETE, 10'd0, 10'd0, 8'd16));
    pending_requests.push_back(make_request(CMD_READ, 10'd0, 10'd0, 8'd16));
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) filling = !filling;
      pending_requests.push_back(random_request(filling));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
